>>> design/dcsu_pkg.sv
// ----------------------------------------------------------------------------
// dcsu_pkg
// Types and codes shared by the DMA channel service update unit.
// ----------------------------------------------------------------------------
package dcsu_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_MASK_8BIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_MASK_16BIT = 1'd1;

	localparam logic [1:0] UK_NONE   = 2'd0;
	localparam logic [1:0] UK_STATUS = 2'd1;
	localparam logic [1:0] UK_FULL   = 2'd2;

	localparam logic [15:0] COUNT_TERMINAL = 16'hffff;
	localparam logic [15:0] BASE_ADDR_RST  = 16'h0000;
	localparam logic [15:0] BASE_COUNT_RST = 16'hffff;
	localparam logic [7:0]  PAGE_MASK_RST  = 8'hff;
	localparam logic [7:0]  TC_BIT0        = 8'h01;
	localparam logic [7:0]  DREQ_BIT0      = 8'h10;

	typedef struct packed {
		logic [2:0]  channel;
		logic        channel_active;
		logic [7:0]  page;
		logic [15:0] current_addr;
		logic [15:0] current_count;
		logic [7:0]  mode_reg;
		logic [7:0]  mask_reg;
		logic [7:0]  status_reg;
		logic [16:0] units_moved;
	} in_word_t;

	typedef struct packed {
		logic [15:0] new_addr;
		logic [15:0] new_count;
		logic [7:0]  new_status;
		logic [1:0]  update_kind;
		logic        handler_called;
		logic [23:0] physical_addr;
		logic [1:0]  transfer_type;
		logic [1:0]  transfer_mode;
		logic        auto_init;
		logic        descending;
		logic [16:0] max_units;
		logic        terminal_reached;
	} out_word_t;

	typedef struct packed {
		logic [15:0] addr;
		logic [15:0] count;
	} base_pair_t;

	typedef struct packed {
		logic       en;
		base_pair_t data;
	} base_wr_t;

endpackage

>>> design/dcsu_base_file.sv
// ----------------------------------------------------------------------------
// dcsu_base_file
// Per-channel base address and base count registers.
// ----------------------------------------------------------------------------
module dcsu_base_file
	import dcsu_pkg::*;
#(
	parameter int NUM_CHANNELS = 8,
	parameter int IDX_W        = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  base_wr_t         wr,
	output base_pair_t       rd
);

	base_pair_t base_q [NUM_CHANNELS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				base_q[i].addr  <= BASE_ADDR_RST;
				base_q[i].count <= BASE_COUNT_RST;
			end
		end else if (wr.en) begin
			base_q[idx] <= wr.data;
		end
	end

	assign rd = base_q[idx];

endmodule

>>> design/dcsu_update.sv
// ----------------------------------------------------------------------------
// dcsu_update
// Service poll decode and next address, count and status for one channel.
// ----------------------------------------------------------------------------
module dcsu_update
	import dcsu_pkg::*;
(
	input  in_word_t   word,
	input  logic       in_range,
	input  base_pair_t base,
	input  logic [7:0] page_mask_8bit,
	input  logic [7:0] page_mask_16bit,
	output out_word_t  res,
	output base_wr_t   base_wr
);

	logic [7:0]  chmask;
	logic [7:0]  dreqmask;
	logic [7:0]  setst;
	logic [16:0] maxu;
	logic [16:0] n;
	logic        differ;
	logic [15:0] eba;
	logic [15:0] ebc;
	logic        masked;
	logic        halted;

	assign chmask   = TC_BIT0 << word.channel[1:0];
	assign dreqmask = DREQ_BIT0 << word.channel[1:0];
	assign setst    = word.status_reg | dreqmask;
	assign maxu     = {1'b0, word.current_count} + 17'd1;
	assign n        = (word.units_moved > maxu) ? maxu : word.units_moved;
	assign differ   = ({1'b0, base.addr} + {1'b0, base.count})
		!= ({1'b0, word.current_addr} + {1'b0, word.current_count});
	assign eba      = differ ? word.current_addr : base.addr;
	assign ebc      = differ ? word.current_count : base.count;
	assign masked   = (word.mask_reg & chmask) != 8'd0;
	assign halted   = !word.mode_reg[4] && (word.current_count == COUNT_TERMINAL);

	assign base_wr.en         = in_range && word.channel_active && differ;
	assign base_wr.data.addr  = word.current_addr;
	assign base_wr.data.count = word.current_count;

	always_comb begin
		res = '0;
		res.new_addr      = word.current_addr;
		res.new_count     = word.current_count;
		res.new_status    = word.status_reg;
		res.update_kind   = UK_NONE;
		res.transfer_type = word.mode_reg[3:2];
		res.transfer_mode = word.mode_reg[7:6];
		res.auto_init     = word.mode_reg[4];
		res.descending    = word.mode_reg[5];
		res.max_units     = maxu;
		if (word.channel[2]) begin
			res.physical_addr = {word.page & page_mask_16bit, word.current_addr[14:0], 1'b0};
		end else begin
			res.physical_addr = {word.page & page_mask_8bit, word.current_addr};
		end
		if (in_range) begin
			if (!word.channel_active) begin
				res.new_status  = word.status_reg & ~dreqmask;
				res.update_kind = UK_STATUS;
			end else if (masked) begin
				res.new_status  = setst;
				res.update_kind = UK_STATUS;
			end else if (!halted) begin
				res.handler_called = 1'b1;
				if (n == 17'd0) begin
					res.new_status  = setst & ~dreqmask;
					res.update_kind = UK_STATUS;
				end else if (n > {1'b0, word.current_count}) begin
					res.terminal_reached = 1'b1;
					res.update_kind      = UK_FULL;
					if (word.mode_reg[4]) begin
						res.new_status = setst | chmask;
						res.new_addr   = eba;
						res.new_count  = ebc;
					end else begin
						res.new_status = (setst | chmask) & ~dreqmask;
						res.new_addr   = word.mode_reg[5] ? (eba - ebc - 16'd1)
							: (eba + ebc + 16'd1);
						res.new_count  = COUNT_TERMINAL;
					end
				end else begin
					res.update_kind = UK_FULL;
					res.new_status  = setst;
					res.new_addr    = word.mode_reg[5] ? (word.current_addr - n[15:0])
						: (word.current_addr + n[15:0]);
					res.new_count   = word.current_count - n[15:0];
				end
			end
		end
	end

endmodule

>>> design/dma_channel_service_update_unit.sv
// ----------------------------------------------------------------------------
// dma_channel_service_update_unit
// Service poll update for 8237-style DMA channels.
// ----------------------------------------------------------------------------
// One poll word is taken every cycle while in_stall is low. A poll is captured
// in the stage-one register, evaluated there against the channel's base
// registers and lands in the output register when the output can load. The
// base registers are written as a poll leaves stage one, so back-to-back polls
// on the same channel always see each other's reprogramming. The output
// register holds a result while the sink stalls; input stalls only when both
// stages are full. The user must write page masks through the config port
// only while idle; the block itself does not enforce this.
module dma_channel_service_update_unit
	import dcsu_pkg::*;
#(
	parameter int NUM_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [7:0] page_mask_8bit_q;
	logic [7:0] page_mask_16bit_q;
	logic       in_valid_s1;
	in_word_t   in_word_s1;
	logic       out_valid_q;
	out_word_t  out_word_q;
	logic       out_load;
	logic       advance;
	logic       in_range;
	base_pair_t base_rd;
	base_wr_t   base_wr_raw;
	base_wr_t   base_wr;
	out_word_t  res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_mask_8bit_q  <= PAGE_MASK_RST;
			page_mask_16bit_q <= PAGE_MASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PAGE_MASK_8BIT:  page_mask_8bit_q  <= cfg_data;
				CFG_PAGE_MASK_16BIT: page_mask_16bit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign out_load = !out_valid_q || !out_stall;
	assign advance  = in_valid_s1 && out_load;
	assign in_stall = in_valid_s1 && !out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			in_valid_s1 <= 1'b1;
		end else if (advance) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			in_word_s1 <= in_word;
		end
	end

	assign in_range = {1'b0, in_word_s1.channel} < 4'(NUM_CHANNELS);

	dcsu_base_file #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.IDX_W       (IDX_W)
	) u_base (
		.clk   (clk),
		.arst_n(arst_n),
		.idx   (in_word_s1.channel[IDX_W-1:0]),
		.wr    (base_wr),
		.rd    (base_rd)
	);

	dcsu_update u_update (
		.word           (in_word_s1),
		.in_range       (in_range),
		.base           (base_rd),
		.page_mask_8bit (page_mask_8bit_q),
		.page_mask_16bit(page_mask_16bit_q),
		.res            (res),
		.base_wr        (base_wr_raw)
	);

	assign base_wr.en   = base_wr_raw.en && advance;
	assign base_wr.data = base_wr_raw.data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= in_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_word_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

>>> design/dcsu_checker.sv
// ----------------------------------------------------------------------------
// dcsu_checker
// Port-level checks on the service update unit, bound to the top level.
// ----------------------------------------------------------------------------
module dcsu_checker
	import dcsu_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_word
);

	// stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result dropped or changed while stalled");

	// terminal count only with a served handler and a full write-back
	a_term_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.terminal_reached |->
		out_word.handler_called && out_word.update_kind == UK_FULL)
		else $error("terminal count without full write-back");

	// served handler always leads to some write-back
	a_called_write: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.handler_called |-> out_word.update_kind != UK_NONE)
		else $error("handler served with no write-back");

	// full write-back only from a served handler
	a_full_called: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.update_kind == UK_FULL |-> out_word.handler_called)
		else $error("address write-back without handler");

endmodule

bind dma_channel_service_update_unit dcsu_checker u_dcsu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_word (out_word)
);
